// ----- rtl/blid_pkg.sv -----
// shared types and constants for the battery led indicator
`default_nettype none

package blid_pkg;

	localparam int CAP_W    = 16;
	localparam int THR_W    = 10;
	localparam int DUTY_W   = 7;
	localparam int CHARGE_W = CAP_W + THR_W;
	localparam int TICK_W   = 4;
	localparam int STATE_W  = 3;

	localparam int DIV_STEPS = CHARGE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CHARGE_W-1:0] PERMILLE = CHARGE_W'(1000);
	localparam logic [DUTY_W-1:0]   DUTY_ON  = DUTY_W'(100);

	localparam logic [THR_W-1:0] CRIT_RST = THR_W'(71);
	localparam logic [THR_W-1:0] LOW_RST  = THR_W'(137);
	localparam logic [THR_W-1:0] FULL_RST = THR_W'(937);

	typedef enum logic [STATE_W-1:0] {
		CHG_CHARGE    = 3'd0,
		CHG_NEAR_FULL = 3'd1,
		CHG_DISCHARGE = 3'd2,
		CHG_ERROR     = 3'd3,
		CHG_IDLE      = 3'd4,
		CHG_OTHER     = 3'd5
	} chg_state_t;

	typedef enum logic [1:0] {
		REG_CRIT = 2'd0,
		REG_LOW  = 2'd1,
		REG_FULL = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		COLOR_OFF,
		COLOR_ORANGE,
		COLOR_BLUE
	} color_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic [THR_W-1:0] crit;
		logic [THR_W-1:0] low;
		logic [THR_W-1:0] full;
	} thr_t;

	typedef struct packed {
		chg_state_t        chg;
		logic              force_idle;
		logic              system_off;
		logic [TICK_W-1:0] tick;
	} item_ctx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/blid_tick_if.sv -----
// input channel: one 250 ms tick beat
`default_nettype none

interface blid_tick_if;
	import blid_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATE_W-1:0]  charger_state;
	logic                force_idle;
	logic                system_off;
	logic                auto_enable;
	logic [CAP_W-1:0]    rem_cap;
	logic [CAP_W-1:0]    full_capacity;

	modport source (
		output valid, charger_state, force_idle, system_off, auto_enable,
			rem_cap, full_capacity,
		input  ready
	);

	modport sink (
		input  valid, charger_state, force_idle, system_off, auto_enable,
			rem_cap, full_capacity,
		output ready
	);

endinterface

`default_nettype wire

// ----- rtl/blid_duty_if.sv -----
// output channel: one beat of led pwm duties
`default_nettype none

interface blid_duty_if;
	import blid_pkg::*;

	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] orange_duty;
	logic [DUTY_W-1:0] blue_duty;

	modport source (
		output valid, orange_duty, blue_duty,
		input  ready
	);

	modport sink (
		input  valid, orange_duty, blue_duty,
		output ready
	);

endinterface

`default_nettype wire

// ----- rtl/blid_divider.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module blid_divider (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [blid_pkg::CHARGE_W-1:0]   dividend,
	input  wire  [blid_pkg::CAP_W-1:0]      divisor,
	output blid_pkg::div_stat_t             stat,
	output logic [blid_pkg::CHARGE_W-1:0]   quotient
);
	import blid_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CHARGE_W-1:0]  dvd_q;
	logic [CAP_W-1:0]     div_q;
	logic [CAP_W-1:0]     rem_q;
	logic                 zero_q;

	logic [CAP_W:0]   rem_sh;
	logic [CAP_W:0]   diff;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q, dvd_q[CHARGE_W-1]};
		ge     = rem_sh >= {1'b0, div_q};
		diff   = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[CAP_W-1:0] : rem_sh[CAP_W-1:0];
			dvd_q <= {dvd_q[CHARGE_W-2:0], ge};
		end
	end

	// zero capacity reads as zero charge
	assign quotient  = zero_q ? '0 : dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

// ----- rtl/blid_color.sv -----
// picks the led color from charge, charger state and tick phase
`default_nettype none

module blid_color (
	input  wire  [blid_pkg::CHARGE_W-1:0] charge,
	input  blid_pkg::thr_t                thr,
	input  blid_pkg::item_ctx_t           ctx,
	output logic [blid_pkg::DUTY_W-1:0]   orange_duty,
	output logic [blid_pkg::DUTY_W-1:0]   blue_duty
);
	import blid_pkg::*;

	color_t color;
	logic   fast_on;
	logic   slow_on;
	logic   half_on;

	always_comb begin
		fast_on = !ctx.tick[2];
		slow_on = (ctx.tick[3:2] == 2'b00);
		half_on = !ctx.tick[3];
		case (ctx.chg)
			CHG_CHARGE: begin
				color = (charge < CHARGE_W'(thr.full)) ? COLOR_ORANGE : COLOR_BLUE;
			end
			CHG_NEAR_FULL: begin
				color = COLOR_BLUE;
			end
			CHG_DISCHARGE: begin
				if (!ctx.system_off && charge <= CHARGE_W'(thr.crit))
					color = fast_on ? COLOR_ORANGE : COLOR_OFF;
				else if (!ctx.system_off && charge <= CHARGE_W'(thr.low))
					color = slow_on ? COLOR_ORANGE : COLOR_OFF;
				else
					color = COLOR_OFF;
			end
			CHG_ERROR: begin
				color = fast_on ? COLOR_ORANGE : COLOR_OFF;
			end
			CHG_IDLE: begin
				if (ctx.force_idle)
					color = half_on ? COLOR_BLUE : COLOR_ORANGE;
				else
					color = COLOR_BLUE;
			end
			default: begin
				color = COLOR_OFF;
			end
		endcase
		orange_duty = (color == COLOR_ORANGE) ? DUTY_ON : '0;
		blue_duty   = (color == COLOR_BLUE) ? DUTY_ON : '0;
	end

endmodule

`default_nettype wire

// ----- rtl/battery_led_indicator_top.sv -----
// battery led indicator: apb thresholds, tick sequencer, divider and color pick
// path: a tick beat that yields a result runs the 26 divider steps, then the done flag
//   moves the sequencer to emit, which loads the output register once no unclaimed beat is held
// flow: a new tick is taken only while idle, so the bit-serial divider holds off the next
//   beat until emit; a beat with auto control off or an unknown charger state skips the divider
// reset: arst_n clears the tick counter, sequencer and output valid and loads
//   the threshold registers with 71, 137 and 937
`default_nettype none

module battery_led_indicator_top (
	input  wire                        clk,
	input  wire                        arst_n,
	blid_tick_if.sink                  tick,
	blid_duty_if.source                duty,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire  [3:0]                 paddr,
	input  wire  [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import blid_pkg::*;

	// configuration registers
	thr_t     thr_q;
	reg_idx_t cfg_idx;
	logic     cfg_wr;

	// sequencer
	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [TICK_W-1:0]   tick_q;
	item_ctx_t           ctx_q;

	// divider hookup
	logic                div_start;
	logic [CHARGE_W-1:0] dividend;
	div_stat_t           div_stat;
	logic [CHARGE_W-1:0] charge;

	// output register
	logic                out_valid_q;
	logic [DUTY_W-1:0]   orange_q;
	logic [DUTY_W-1:0]   blue_q;
	logic [DUTY_W-1:0]   orange_nx;
	logic [DUTY_W-1:0]   blue_nx;

	logic tick_acc;
	logic known_state;
	logic emit;
	logic out_free;

	// ---------------------------------------------------------------- apb
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.crit <= CRIT_RST;
			thr_q.low  <= LOW_RST;
			thr_q.full <= FULL_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_CRIT: thr_q.crit <= pwdata[THR_W-1:0];
				REG_LOW:  thr_q.low  <= pwdata[THR_W-1:0];
				REG_FULL: thr_q.full <= pwdata[THR_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_CRIT: prdata = 32'(thr_q.crit);
			REG_LOW:  prdata = 32'(thr_q.low);
			REG_FULL: prdata = 32'(thr_q.full);
			default:  prdata = '0;
		endcase
	end

	// ---------------------------------------------------------- sequencer
	// the input side is open only while idle; a finished result may still
	// sit in the output register while the next tick is taken
	assign tick.ready  = (state_q == ST_IDLE);
	assign tick_acc    = tick.valid && tick.ready;
	assign known_state = tick.charger_state inside
		{CHG_CHARGE, CHG_NEAR_FULL, CHG_DISCHARGE, CHG_ERROR, CHG_IDLE};

	// only ticks that produce a beat go through the divider
	assign div_start = tick_acc && tick.auto_enable && known_state;

	// remaining * 1000 fits in 26 bits, one narrow multiply at load
	assign dividend  = CHARGE_W'(tick.rem_cap) * PERMILLE;

	assign out_free  = !out_valid_q || duty.ready;

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (div_start)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// wait here if the previous beat is still unclaimed
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// the counter advances on every tick, with or without a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tick_q <= '0;
		else if (tick_acc)
			tick_q <= tick_q + 1'b1;
	end

	// per-item context; blinking uses the count after the increment
	always_ff @(posedge clk) begin
		if (div_start) begin
			ctx_q.chg        <= chg_state_t'(tick.charger_state);
			ctx_q.force_idle <= tick.force_idle;
			ctx_q.system_off <= tick.system_off;
			ctx_q.tick       <= tick_q + 1'b1;
		end
	end

	// ------------------------------------------------------------- units
	blid_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (tick.full_capacity),
		.stat     (div_stat),
		.quotient (charge)
	);

	blid_color u_color (
		.charge      (charge),
		.thr         (thr_q),
		.ctx         (ctx_q),
		.orange_duty (orange_nx),
		.blue_duty   (blue_nx)
	);

	// ---------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (duty.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			orange_q <= orange_nx;
			blue_q   <= blue_nx;
		end
	end

	assign duty.valid       = out_valid_q;
	assign duty.orange_duty = orange_q;
	assign duty.blue_duty   = blue_q;

	// -------------------------------------------------------- assertions
	a_no_result_when_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && !tick.auto_enable) |=> (state_q == ST_IDLE))
		else $error("tick with auto control off started work");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> (tick_q == $past(tick_q) + 4'd1))
		else $error("tick counter did not advance on an accepted tick");

	a_divider_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV))
		else $error("divider running outside the divide phase");

	a_one_color: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(orange_nx == DUTY_ON && blue_nx == DUTY_ON))
		else $error("both leds driven at once");

	a_emit_holds_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !duty.ready) |-> !emit)
		else $error("result overwrote an unclaimed beat");

endmodule

`default_nettype wire
